>>> sv/sliding_window_median_filter_core_assert.svh
// Assertion macros used by the median filter core.
// Each macro expects signals named clk and rst in the including module.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks a property on every clock edge outside reset.
`define SWMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a condition never holds outside reset.
`define SWMF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SWMF_ASSERT(lbl, prop, msg)
`define SWMF_NEVER(lbl, cond, msg)
`endif

`endif

>>> sv/swmf_pkg.sv
// Shared types and constants for the sliding window median filter.
// No dependencies.
package swmf_pkg;

  typedef logic signed [11:0] sample_t;
  typedef logic signed [12:0] median_t;

  // Disconnected sensor reading, -127 degrees in 1/16 degree units.
  localparam sample_t DISCONNECTED_SIXTEENTHS = -12'sd2032;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_FINISH
  } swmf_state_t;

endpackage

>>> sv/sliding_window_median_filter_core.sv
// Sliding window median filter for temperature samples in 1/16 degree units.
// Input word: temp_sixteenths and reading_nonfinite on a valid/ready channel.
// A sample is stored unless it is flagged non-finite or equals the
// disconnected reading of -127 degrees; it then replaces the oldest slot.
// Output word: median_thirtyseconds, the sum of the two middle values of the
// window (twice the middle value for an odd window), and sample_accepted.
// Exactly one output word follows every input word.
// After the accepting edge the rank unit scores one window slot per cycle
// until every slot is scored, and the finish state then loads the output
// register once it is free. in_ready is low during the rank and finish
// states, so a new word is taken only after the previous one has been
// loaded into the output register.
// The output register holds the result until it is taken; while it is still
// full the next item may be accepted and ranked, and it waits in the finish
// cycle until the receiver takes the older word.
// Reset clears the window to zero and the write slot to zero, drops
// out_valid and returns to idle. Reset zeros count as samples until they are overwritten.
module sliding_window_median_filter_core
  import swmf_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [11:0]  temp_sixteenths,
  input  logic                reading_nonfinite,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [12:0]  median_thirtyseconds,
  output logic                sample_accepted
);

`include "sliding_window_median_filter_core_assert.svh"

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RANK_W = $clog2(WINDOW + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [RANK_W-1:0] RANK_LO   = RANK_W'((WINDOW - 1) / 2);
  localparam logic [RANK_W-1:0] RANK_HI   = RANK_W'(WINDOW / 2);

  swmf_state_t state, state_next;

  sample_t           window [WINDOW];
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] cand;
  sample_t           lo_val;
  sample_t           hi_val;
  logic              lo_found;
  logic              hi_found;
  logic              accepted;

  logic              in_fire;
  logic              take_sample;
  logic              out_free;
  logic [SLOT_W-1:0] slot_eff;
  sample_t           cand_val;
  logic [RANK_W-1:0] cand_rank;

  swmf_rank_unit #(
    .WINDOW (WINDOW)
  ) u_rank (
    .win      (window),
    .cand_idx (cand),
    .cand_val (cand_val),
    .rank     (cand_rank)
  );

  assign in_ready    = (state == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign take_sample = !reading_nonfinite && (temp_sixteenths != DISCONNECTED_SIXTEENTHS);
  assign out_free    = !out_valid || out_ready;
  assign slot_eff    = (32'(write_slot) >= WINDOW) ? '0 : write_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_RANK;
        end
      end
      ST_RANK: begin
        if (cand == LAST_SLOT) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Window store and write slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        window[i] <= '0;
      end
      write_slot <= '0;
    end else if (in_fire && take_sample) begin
      window[slot_eff] <= temp_sixteenths;
      write_slot       <= (slot_eff == LAST_SLOT) ? '0 : slot_eff + SLOT_W'(1);
    end
  end

  // Rank pass over the window, one candidate slot per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cand     <= '0;
      lo_found <= 1'b0;
      hi_found <= 1'b0;
    end else if (in_fire) begin
      cand     <= '0;
      lo_found <= 1'b0;
      hi_found <= 1'b0;
    end else if (state == ST_RANK) begin
      if (cand_rank == RANK_LO) begin
        lo_found <= 1'b1;
      end
      if (cand_rank == RANK_HI) begin
        hi_found <= 1'b1;
      end
      if (cand != LAST_SLOT) begin
        cand <= cand + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      accepted <= take_sample;
    end
    if (state == ST_RANK) begin
      if (cand_rank == RANK_LO) begin
        lo_val <= cand_val;
      end
      if (cand_rank == RANK_HI) begin
        hi_val <= cand_val;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      median_thirtyseconds <= {lo_val[11], lo_val} + {hi_val[11], hi_val};
      sample_accepted      <= accepted;
    end
  end

  `SWMF_ASSERT(a_busy_after_accept, in_fire |=> !in_ready, "accepted word did not start a rank pass")
  `SWMF_NEVER(a_slot_range, 32'(write_slot) >= WINDOW, "write slot out of window range")
  `SWMF_ASSERT(a_ranks_found, (state == ST_FINISH) |-> (lo_found && hi_found), "median ranks not found in rank pass")
  `SWMF_ASSERT(a_reject_holds_slot, (in_fire && !take_sample) |=> $stable(write_slot), "rejected sample moved write slot")

endmodule

>>> sv/swmf_rank_unit.sv
// Rank unit: compares one candidate against every window entry combinationally.
// Depends on swmf_pkg. Ties are broken by slot index so ranks are unique.
module swmf_rank_unit
  import swmf_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  sample_t                               win [WINDOW],
  input  logic [(WINDOW > 1 ? $clog2(WINDOW) : 1)-1:0] cand_idx,
  output sample_t                               cand_val,
  output logic [$clog2(WINDOW + 1)-1:0]         rank
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RANK_W = $clog2(WINDOW + 1);

  assign cand_val = win[cand_idx];

  // Rank counts entries strictly smaller, plus equal entries in lower slots.
  always_comb begin
    logic [RANK_W-1:0] acc;
    logic              below;
    acc = '0;
    for (int j = 0; j < WINDOW; j++) begin
      below = (win[j] < cand_val) ||
              ((win[j] == cand_val) && (SLOT_W'(j) < cand_idx));
      acc = acc + RANK_W'(below);
    end
    rank = acc;
  end

endmodule

>>> sim/median_checker.sv
// Checker for the sliding window median filter: watches both channels, keeps its own
// copy of the sample window and compares every output word with the predicted median.
// Depends on swmf_pkg for the sample and median types and the disconnected reading.
module median_checker
  import swmf_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  sample_t  temp_sixteenths,
  input  logic     reading_nonfinite,
  input  logic     out_valid,
  input  logic     out_ready,
  input  median_t  median_thirtyseconds,
  input  logic     sample_accepted,
  output int       mismatch_count,
  output int       pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    median_t median;
    logic    accepted;
  } filter_word_t;

  filter_word_t expected_words[$];
  sample_t      window_copy[WINDOW];
  int unsigned  next_slot;
  int           errors;

  // Median in 1/32 degree units: the sum of the two middle samples, or twice
  // the middle one when the window is odd.
  function automatic median_t window_median_x2();
    sample_t sorted[WINDOW];
    sample_t key;
    int      i;
    int      j;
    int      sum;
    sorted = window_copy;
    for (i = 1; i < WINDOW; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = key;
    end
    if (WINDOW % 2 == 0)
      sum = sorted[WINDOW / 2 - 1] + sorted[WINDOW / 2];
    else
      sum = 2 * sorted[WINDOW / 2];
    return median_t'(sum);
  endfunction

  always @(posedge clk) begin
    filter_word_t want;
    if (rst) begin
      foreach (window_copy[k]) window_copy[k] = '0;
      next_slot = 0;
      expected_words.delete();
    end else begin
      // Retire before predicting: a word cannot leave in the cycle it enters.
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t unexpected output word: median %0d, accepted %0b", $time,
                   median_thirtyseconds, sample_accepted);
        end else begin
          want = expected_words.pop_front();
          if (median_thirtyseconds !== want.median) begin
            errors++;
            $display("%0t median_thirtyseconds mismatch: expected %0d, actual %0d", $time,
                     want.median, median_thirtyseconds);
          end
          if (sample_accepted !== want.accepted) begin
            errors++;
            $display("%0t sample_accepted mismatch: expected %0b, actual %0b", $time,
                     want.accepted, sample_accepted);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (!reading_nonfinite && temp_sixteenths != DISCONNECTED_SIXTEENTHS) begin
          if (next_slot >= WINDOW) next_slot = 0;
          window_copy[next_slot] = temp_sixteenths;
          next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
          want.accepted = 1'b1;
        end else begin
          want.accepted = 1'b0;
        end
        want.median = window_median_x2();
        expected_words.push_back(want);
      end
    end
    mismatch_count <= errors;
    pending_words  <= expected_words.size();
  end

endmodule

>>> sim/testbench.sv
// Top of the median filter testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on swmf_pkg, sliding_window_median_filter_core and median_checker.
module testbench;
  import swmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      WINDOW       = 8;
  localparam int      RANDOM_WORDS = 880;
  localparam int      STALL_LIMIT  = 4000;
  localparam int      SETTLE       = 4 * (WINDOW + 2);
  localparam sample_t TEMP_MAX     = 12'sd2047;
  localparam sample_t TEMP_MIN     = -12'sd2048;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sample_t  temp_sixteenths = '0;
  logic     reading_nonfinite = 1'b0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  median_t  median_thirtyseconds;
  logic     sample_accepted;
  int       mismatch_count;
  int       pending_words;

  rx_mode_t    rx_mode = RX_ALWAYS;
  int          rx_phase_left = 0;
  int unsigned rx_cycle = 0;
  int          idle_cycles;

  sliding_window_median_filter_core #(.WINDOW(WINDOW)) DUT (.*);

  median_checker #(.WINDOW(WINDOW)) u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver picks a new random stall behavior at the end of each random-length phase.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_phase_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_phase_left <= $urandom_range(20, 200);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_HALF:     out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   out_ready <= ($urandom_range(0, 4) == 0);
      RX_PERIODIC: out_ready <= (rx_cycle % 7) < 3;
    endcase
  end

  // Called in the time step of a rising edge; returns at the edge that takes the word.
  task automatic send_word(input sample_t temp, input logic nonfinite);
    in_valid <= 1'b1;
    temp_sixteenths <= temp;
    reading_nonfinite <= nonfinite;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  initial begin
    int      n;
    int      burst_left;
    int      pick;
    sample_t temp;
    logic    nonfinite;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rejected words first, so the median still comes from the reset zeros; the next two are accepted neighbours of it.
    send_word(DISCONNECTED_SIXTEENTHS, 1'b0);
    send_word(TEMP_MAX, 1'b1);
    send_word(DISCONNECTED_SIXTEENTHS, 1'b1);
    send_word(DISCONNECTED_SIXTEENTHS + 12'sd1, 1'b0);
    send_word(DISCONNECTED_SIXTEENTHS - 12'sd1, 1'b0);
    repeat (WINDOW) send_word(TEMP_MIN, 1'b0);
    repeat (WINDOW) send_word(TEMP_MAX, 1'b0);
    send_word(12'sd1, 1'b0);
    send_word(-12'sd1, 1'b0);
    send_word('0, 1'b1);
    wait_for_drain();

    burst_left = 0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 40));
      end
      pick = $urandom_range(0, 99);
      nonfinite = 1'b0;
      if (pick < 8) begin
        temp = DISCONNECTED_SIXTEENTHS;
        nonfinite = 1'($urandom_range(0, 1));
      end else if (pick < 18) begin
        temp = sample_t'($urandom_range(0, 4095));
        nonfinite = 1'b1;
      end else if (pick < 38) begin
        // A narrow band gives repeated values and ties around the middle.
        temp = sample_t'(int'($urandom_range(0, 40)) - 20);
      end else if (pick < 45) begin
        case ($urandom_range(0, 3))
          0:       temp = TEMP_MAX;
          1:       temp = TEMP_MIN;
          2:       temp = DISCONNECTED_SIXTEENTHS + 12'sd1;
          default: temp = DISCONNECTED_SIXTEENTHS - 12'sd1;
        endcase
      end else begin
        temp = sample_t'($urandom_range(0, 4095));
      end
      send_word(temp, nonfinite);
      burst_left--;
      if (n == RANDOM_WORDS / 2) wait_for_drain();
    end

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Ends a hung run: counts cycles in which neither channel moves a word.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
